@@ sv/bdq_pkg.sv @@
// Shared types and constants for the bounded deque with remove by value.
// No dependencies; imported by bdq_ctrl, bdq_dp and the top level.
package bdq_pkg;

  // Field widths of the request and result words
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned OCC_W    = 7;

  // Request codes; the two remaining codes are ignored requests
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_FIND       = 3'd4,
    FN_REMOVE     = 3'd5
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Store operations the datapath applies
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_REMOVE
  } dp_op_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;       // capture the request word
    logic    capture;    // load per-cell match flags into the search tree
    dp_op_e  op;         // store update for this cycle
    logic    result;     // write the result word
    status_e status;     // result status
    logic    use_pos;    // result position from the search tree
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              found;
  } dp_stat_t;

endpackage

@@ sv/bdq_dp.sv @@
// Datapath: row of storage cells with shift and compare, registered
// priority tree for the first match, occupancy counter and result word.
// Depends on bdq_pkg.
module bdq_dp
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_stat_t                   stat_o,
  input  logic [FUNC_W-1:0]          func_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [POS_W-1:0]           position_o,
  output logic [OCC_W-1:0]           occupancy_o
);

  localparam int unsigned LW = $clog2(DEPTH);
  localparam int unsigned P  = 1 << LW;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Request word
  logic [FUNC_W-1:0]         func_q;
  logic signed [VALUE_W-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      val_q  <= value_i;
    end
  end

  // Occupancy
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      OP_PUSH_FRONT, OP_PUSH_BACK:          count_d = count_q + CW'(1);
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: count_d = count_q - CW'(1);
      default:                              count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Match flags, one per cell, padded to a power of two
  logic [P-1:0] match_q, match_d;
  logic signed [VALUE_W-1:0] cell_q [DEPTH];

  always_comb begin
    match_d = '0;
    for (int j = 0; j < DEPTH; j++) begin
      match_d[j] = (cell_q[j] == val_q) && (CW'(j) < count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      match_q <= match_d;
    end
  end

  // Priority tree, heap order: node k has children 2k and 2k+1, and
  // children at or above P are the match flags. One level settles per cycle.
  logic          node_v_q [1:P-1];
  logic [LW-1:0] node_i_q [1:P-1];

  for (genvar k = 1; k < P; k++) begin : g_node
    logic          lv, rv;
    logic [LW-1:0] li, ri;
    if (2 * k >= P) begin : g_leaf
      assign lv = match_q[2*k-P];
      assign rv = match_q[2*k+1-P];
      assign li = LW'(2 * k - P);
      assign ri = LW'(2 * k + 1 - P);
    end else begin : g_inner
      assign lv = node_v_q[2*k];
      assign rv = node_v_q[2*k+1];
      assign li = node_i_q[2*k];
      assign ri = node_i_q[2*k+1];
    end
    always_ff @(posedge clk_i) begin
      node_v_q[k] <= lv | rv;
      node_i_q[k] <= lv ? li : ri;
    end
  end

  // Cell row: shift toward the back on push front, close the gap above
  // the shift index on pop front and remove, write at the tail on push back
  logic [LW-1:0] shift_idx;
  assign shift_idx = (cmd_i.op == OP_REMOVE) ? node_i_q[1] : '0;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic signed [VALUE_W-1:0] prev, next, cell_d;
    if (j == 0) begin : g_head
      assign prev = val_q;
    end else begin : g_body
      assign prev = cell_q[j-1];
    end
    if (j == DEPTH - 1) begin : g_tail
      assign next = cell_q[j];
    end else begin : g_mid
      assign next = cell_q[j+1];
    end

    always_comb begin
      cell_d = cell_q[j];
      case (cmd_i.op)
        OP_PUSH_FRONT: cell_d = prev;
        OP_PUSH_BACK: begin
          if (count_q == CW'(j)) cell_d = val_q;
        end
        OP_POP_FRONT, OP_REMOVE: begin
          if (LW'(j) >= shift_idx) cell_d = next;
        end
        default: cell_d = cell_q[j];
      endcase
    end

    always_ff @(posedge clk_i) begin
      cell_q[j] <= cell_d;
    end
  end

  // Status to the controller
  assign stat_o.func  = func_q;
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.found = node_v_q[1];

  // Result word; done_o marks it for one cycle
  logic [LW+POS_W-1:0] pos_wide;
  logic [CW+OCC_W-1:0] occ_wide;
  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [POS_W-1:0]    pos_q;
  logic [OCC_W-1:0]    occ_q;

  assign pos_wide = {{POS_W{1'b0}}, (cmd_i.use_pos ? node_i_q[1] : {LW{1'b0}})};
  assign occ_wide = {{OCC_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      status_q <= cmd_i.status;
      pos_q    <= pos_wide[POS_W-1:0];
      occ_q    <= occ_wide[OCC_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;
  assign occupancy_o = occ_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe on consecutive cycles");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.result && cmd_i.status == ST_FULL) |-> count_q == CW'(DEPTH))
    else $error("full status while store not full");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.result && cmd_i.status == ST_EMPTY) |-> count_q == '0)
    else $error("empty status while store holds words");

endmodule

@@ sv/bdq_ctrl.sv @@
// Controller: request sequencing, search wait and result commands.
// Depends on bdq_pkg; drives bdq_dp through dp_cmd_t.
module bdq_ctrl
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam int unsigned LW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(LW + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // State and search counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '{load: 1'b0, capture: 1'b0, op: OP_NONE, result: 1'b0,
                status: ST_DONE, use_pos: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d      = S_IDLE;
        cmd_o.result = 1'b1;
        case (stat_i.func)
          FN_PUSH_FRONT: begin
            if (stat_i.full) cmd_o.status = ST_FULL;
            else             cmd_o.op     = OP_PUSH_FRONT;
          end
          FN_PUSH_BACK: begin
            if (stat_i.full) cmd_o.status = ST_FULL;
            else             cmd_o.op     = OP_PUSH_BACK;
          end
          FN_POP_FRONT: begin
            if (stat_i.empty) cmd_o.status = ST_EMPTY;
            else              cmd_o.op     = OP_POP_FRONT;
          end
          FN_POP_BACK: begin
            if (stat_i.empty) cmd_o.status = ST_EMPTY;
            else              cmd_o.op     = OP_POP_BACK;
          end
          FN_FIND, FN_REMOVE: begin
            cmd_o.result  = 1'b0;
            cmd_o.capture = 1'b1;
            cnt_d         = '0;
            state_d       = S_SEARCH;
          end
          default: cmd_o.op = OP_NONE;
        endcase
      end
      S_SEARCH: begin
        // one tree level settles per cycle
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(LW - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        state_d      = S_IDLE;
        cmd_o.result = 1'b1;
        if (stat_i.found) begin
          cmd_o.use_pos = 1'b1;
          if (stat_i.func == FN_REMOVE) cmd_o.op = OP_REMOVE;
        end else begin
          cmd_o.status = ST_NOTFOUND;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // Checks
  a_start_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q == S_EXEC)
    else $error("accepted request not executed");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |=> state_q == S_IDLE)
    else $error("search result not closed");

  a_search_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> cnt_q <= CNT_W'(LW - 1))
    else $error("search counter overran tree depth");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result |=> state_q == S_IDLE)
    else $error("result written outside request end");

endmodule

@@ sv/bounded_deque_with_remove_by_value.sv @@
// Channel  | Ports                                  | Direction | Handshake
// request  | func_i, value_i                        | in        | start_i & !busy_o
// result   | status_o, position_o, occupancy_o      | out       | done_o, one cycle
//
// Push, pop and ignored requests pass through S_EXEC, from which done_o is registered.
// Find and remove pass through S_EXEC, S_SEARCH and S_FINISH, waiting on the
// registered priority tree that locates the first match, one level a cycle.
// A new request may be accepted in the cycle done_o is shown.
// Reset clears the occupancy and the controller; stored words need no clear.
// Results cannot be stalled: done_o marks each result for exactly one cycle.
//
// Top level: bdq_ctrl controller plus bdq_dp datapath. Depends on bdq_pkg.
module bounded_deque_with_remove_by_value
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [FUNC_W-1:0]          func_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [POS_W-1:0]           position_o,
  output logic [OCC_W-1:0]           occupancy_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (func_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .position_o  (position_o),
    .occupancy_o (occupancy_o)
  );

endmodule
